// File: rtl/four_channel_sound_generator_unit_defines.svh
// Assertion macros for the four-channel sound generator.
// Included by the top level; no other dependencies.
`ifndef FOUR_CHANNEL_SOUND_GENERATOR_UNIT_DEFINES_SVH
`define FOUR_CHANNEL_SOUND_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FCSG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FCSG_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCSG_ASSERT(label, clk, rst, prop, msg)
`define FCSG_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: rtl/fcsg_pkg.sv
// Shared types, constants and functions of the four-channel sound generator.
// No dependencies.
`default_nettype none
package fcsg_pkg;
   localparam int unsigned CpuClockHz = 4194304;
   localparam logic [2:0] RegSq1 = 3'd0, RegSq2 = 3'd1, RegWave = 3'd2, RegNoise = 3'd3,
      RegMixer = 3'd4, RegTblLo = 3'd5, RegTblHi = 3'd6;
   localparam logic ReqTick = 1'b0;
   localparam logic ReqSample = 1'b1;

   // Steps of the shared divider, run in this order on every tick transaction with master enable set.
   localparam logic [3:0] DivSq1Freq = 4'd0, DivSq1Per = 4'd1, DivSq2Freq = 4'd2,
      DivSq2Per = 4'd3, DivWavFreq = 4'd4, DivWavPer = 4'd5, DivNoiFreq = 4'd6,
      DivNoiPer = 4'd7, DivRemSq1 = 4'd8, DivRemSq2 = 4'd9, DivRemWav = 4'd10,
      DivRemNoi = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_DIVWAIT, ST_RUN, ST_STEP, ST_MIX, ST_OUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       div_start;   // start a divide
      logic [3:0] div_sel;     // which division
      logic       div_latch;   // store divider result
      logic       load_count;  // take cycle count
      logic       tick_step;   // advance one emulated cycle
      logic       mix_go;      // capture mix
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic count_zero;
      logic master_en;
   } status_type;

   function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] ph);
      logic [7:0] pat;
      case (duty)
         2'd0: pat = 8'b1000_0000;
         2'd1: pat = 8'b1000_0001;
         2'd2: pat = 8'b1110_0001;
         default: pat = 8'b0111_1110;
      endcase
      return pat[ph];
   endfunction
endpackage
`default_nettype wire

// File: rtl/four_channel_sound_generator_unit.sv
// Channel     | Handshake            | Payload
// req         | req_valid/req_stall  | req_type, req_cycle_count
// rsp         | rsp_valid/rsp_stall  | rsp_left_sample, rsp_right_sample
// csr         | csr_write            | csr_index, csr_data
// A tick runs the shared divider 12 times (periods, then residues), then steps
// once per emulated clock (ST_RUN, ST_STEP) until cycle_count is used up; with
// master off, it does neither. A sample is captured in ST_MIX and held valid in
// ST_OUT until rsp_stall is low. Reset is synchronous.
// Depends on fcsg_pkg, fcsg_controller, fcsg_datapath and the defines header.
`default_nettype none
`include "four_channel_sound_generator_unit_defines.svh"
module four_channel_sound_generator_unit import fcsg_pkg::*; #(
   parameter int unsigned CPU_CLOCK_HZ = CpuClockHz
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_cycle_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   cmd_type    cmd;
   status_type status;

   fcsg_controller u_ctl (
      .clock, .reset, .req_valid, .req_type, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   fcsg_datapath #(.CPU_CLOCK_HZ(CPU_CLOCK_HZ)) u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .cycle_count(req_cycle_count),
      .cmd, .status, .left_mix(rsp_left_sample), .right_mix(rsp_right_sample)
   );

   `FCSG_ASSERT(a_no_accept_busy, clock, reset, rsp_valid |-> req_stall, "accept while busy")
   `FCSG_ASSERT(a_one_cmd, clock, reset, $onehot0({cmd.tick_step, cmd.mix_go, cmd.div_start}), "clash")
   `FCSG_ASSERT(a_rsp_follow, clock, reset, cmd.mix_go |=> rsp_valid, "sample result missing")
endmodule
`default_nettype wire

// File: rtl/fcsg_divider.sv
// Radix-2 restoring divider, one quotient bit a cycle, 32-bit operands.
// Gives quotient and remainder; depends on fcsg_pkg.
`default_nettype none
module fcsg_divider import fcsg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (start) begin
         rem_in = '0; quo_in = dividend; den_in = divisor; cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0]; quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]}; quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
   end

   assign done = busy_ff && (cnt_ff == 6'd1);
   // A zero divisor never occurs here; the result then is all ones.
   assign quotient = trial[32] ? {quo_ff[30:0], 1'b0} : {quo_ff[30:0], 1'b1};
   assign remainder = trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];
endmodule
`default_nettype wire

// File: rtl/fcsg_datapath.sv
// Datapath: registers, channel state, period divisions, modulo counters, mixer.
// Depends on fcsg_pkg and fcsg_divider.
`default_nettype none
module fcsg_datapath import fcsg_pkg::*; #(
   parameter int unsigned CPU_CLOCK_HZ = CpuClockHz
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   input  wire logic [7:0]  cycle_count,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic signed [15:0] left_mix,
   output logic signed [15:0] right_mix
);
   localparam logic [31:0] Clk = 32'(CPU_CLOCK_HZ);

   logic [31:0] sq1_ff, sq2_ff, wav_ff;
   logic [23:0] noi_ff, mix_ff;
   logic [63:0] tlo_ff, thi_ff;
   logic [2:0]  ph1_ff, ph2_ff;
   logic [4:0]  widx_ff;
   logic [14:0] lfsr_ff;
   logic [7:0]  cnt_ff;
   logic [31:0] p_ff [4];
   logic [31:0] m_ff [4];   // tick_total modulo each period
   logic [31:0] q_ff;
   logic [31:0] tt_ff, tt_in;
   logic signed [15:0] l_ff, r_ff;

   // Division operands by step; freq results chain through q_ff.
   logic [31:0] dvd, dvs, q, rmd;
   logic        dv_done;
   logic [10:0] c1, c2, c3;
   logic [7:0]  nctl;
   logic [7:0]  ndiv;
   assign c1 = {sq1_ff[26:24], sq1_ff[23:16]};
   assign c2 = {sq2_ff[26:24], sq2_ff[23:16]};
   assign c3 = {wav_ff[26:24], wav_ff[23:16]};
   assign nctl = noi_ff[15:8];
   assign ndiv = (nctl[2:0] == 3'd0) ? 8'd8 : {1'b0, nctl[2:0], 4'd0};

   always_comb begin
      case (cmd.div_sel)
         DivSq1Freq: begin dvd = 32'd131072; dvs = 32'd2048 - 32'(c1); end
         DivSq1Per: begin dvd = Clk; dvs = {q_ff[28:0], 3'd0}; end
         DivSq2Freq: begin dvd = 32'd131072; dvs = 32'd2048 - 32'(c2); end
         DivSq2Per: begin dvd = Clk; dvs = {q_ff[28:0], 3'd0}; end
         DivWavFreq: begin dvd = 32'd65536; dvs = 32'd2048 - 32'(c3); end
         DivWavPer: begin dvd = Clk; dvs = {q_ff[26:0], 5'd0}; end
         DivNoiFreq: begin dvd = Clk; dvs = 32'(ndiv) << nctl[7:4]; end
         DivNoiPer: begin dvd = Clk; dvs = q_ff; end
         DivRemSq1: begin dvd = tt_ff; dvs = p_ff[0]; end
         DivRemSq2: begin dvd = tt_ff; dvs = p_ff[1]; end
         DivRemWav: begin dvd = tt_ff; dvs = p_ff[2]; end
         DivRemNoi: begin dvd = tt_ff; dvs = p_ff[3]; end
         default: begin dvd = '0; dvs = '0; end
      endcase
   end

   fcsg_divider u_div (
      .clock, .reset, .start(cmd.div_start), .dividend(dvd),
      .divisor((dvs == '0) ? 32'd1 : dvs), .done(dv_done), .quotient(q),
      .remainder(rmd)
   );

   // Zero-divisor cases: freq*8 or freq*32 zero means freq was zero,
   // which cannot happen for squares/wave; noise divisor is never zero;
   // noise freq zero gives period zero.
   always_ff @(posedge clock) begin
      if (cmd.div_latch) begin
         q_ff <= q;
         case (cmd.div_sel)
            DivSq1Per: p_ff[0] <= q;
            DivSq2Per: p_ff[1] <= q;
            DivWavPer: p_ff[2] <= q;
            DivNoiPer: p_ff[3] <= (q_ff == '0) ? 32'd0 : q;
            default: ;
         endcase
      end
   end

   logic [7:0] en;
   logic [3:0] run, due;
   assign en = mix_ff[23:16];
   assign run = {en[3] & noi_ff[22], en[2] & wav_ff[31], en[1] & sq2_ff[30],
                 en[0] & sq1_ff[30]};

   // Wrap of tick_total: when tick_total wraps past 2^32, every modulo counter
   // is reset to zero, not to the true residue.
   logic [31:0] m_in [4];
   always_comb begin
      tt_in = tt_ff + 32'd1;
      for (int k = 0; k < 4; k++) begin
         if (tt_in == 32'd0) m_in[k] = '0;
         else if (m_ff[k] + 32'd1 >= p_ff[k]) m_in[k] = '0;
         else m_in[k] = m_ff[k] + 32'd1;
         due[k] = (p_ff[k] != '0) && (m_in[k] == '0);
      end
   end

   logic fb;
   assign fb = lfsr_ff[0] ^ lfsr_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq1_ff <= '0; sq2_ff <= '0; wav_ff <= '0; noi_ff <= '0; mix_ff <= '0;
         tlo_ff <= '0; thi_ff <= '0; tt_ff <= '0;
         ph1_ff <= '0; ph2_ff <= '0; widx_ff <= '0; lfsr_ff <= 15'h7FFF; cnt_ff <= '0;
         for (int k = 0; k < 4; k++) m_ff[k] <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               RegSq1: sq1_ff <= csr_data[31:0];
               RegSq2: sq2_ff <= csr_data[31:0];
               RegWave: wav_ff <= csr_data[31:0];
               RegNoise: noi_ff <= csr_data[23:0];
               RegMixer: mix_ff <= csr_data[23:0];
               RegTblLo: tlo_ff <= csr_data;
               RegTblHi: thi_ff <= csr_data;
               default: ;
            endcase
         end
         // Residues are rebuilt from tick_total after period change.
         if (cmd.load_count) begin
            cnt_ff <= cycle_count;
         end
         if (cmd.div_latch) begin
            case (cmd.div_sel)
               DivRemSq1: m_ff[0] <= rmd;
               DivRemSq2: m_ff[1] <= rmd;
               DivRemWav: m_ff[2] <= rmd;
               DivRemNoi: m_ff[3] <= rmd;
               default: ;
            endcase
         end
         if (cmd.tick_step) begin
            cnt_ff <= cnt_ff - 8'd1;
            tt_ff <= tt_in;
            for (int k = 0; k < 4; k++) m_ff[k] <= m_in[k];
            if (run[0] && due[0]) ph1_ff <= ph1_ff + 3'd1;
            if (run[1] && due[1]) ph2_ff <= ph2_ff + 3'd1;
            if (run[2] && due[2]) widx_ff <= widx_ff + 5'd1;
            if (run[3] && due[3]) begin
               lfsr_ff <= {fb, lfsr_ff[14:8], (nctl[3] ? fb : lfsr_ff[7]), lfsr_ff[6:1]};
            end
         end
      end
   end

   // Mixer.
   logic [3:0] lv [4];
   logic [7:0] tb;
   logic [3:0] ws;
   logic [1:0] wcode;
   always_comb begin
      tb = widx_ff[4] ? thi_ff[8*widx_ff[3:1] +: 8] : tlo_ff[8*widx_ff[3:1] +: 8];
      ws = widx_ff[0] ? tb[3:0] : tb[7:4];
      wcode = wav_ff[14:13];
      lv[0] = (en[0] && duty_bit(sq1_ff[7:6], ph1_ff)) ? sq1_ff[15:12] : 4'd0;
      lv[1] = (en[1] && duty_bit(sq2_ff[7:6], ph2_ff)) ? sq2_ff[15:12] : 4'd0;
      lv[2] = (en[2] && wav_ff[7] && wcode != 2'd0) ? (ws >> (wcode - 2'd1)) : 4'd0;
      lv[3] = (en[3] && !lfsr_ff[0]) ? noi_ff[7:4] : 4'd0;
   end

   function automatic logic signed [15:0] side(input logic [3:0] a, input logic [3:0] b,
         input logic [3:0] c, input logic [3:0] d, input logic [3:0] pan,
         input logic [2:0] vol);
      logic signed [7:0]  s;
      logic signed [20:0] p;
      s = 8'(pan[0] ? a : 4'd0) + 8'(pan[1] ? b : 4'd0) + 8'(pan[2] ? c : 4'd0)
        + 8'(pan[3] ? d : 4'd0) - 8'sd30;
      p = 21'(s) * $signed({1'b0, 4'(vol) + 4'd1}) * 21'sd136;
      if (p > 21'sd32767) return 16'sh7FFF;
      if (p < -21'sd32768) return 16'sh8000;
      return p[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.mix_go) begin
         l_ff <= side(lv[0], lv[1], lv[2], lv[3], mix_ff[15:12], mix_ff[6:4]);
         r_ff <= side(lv[0], lv[1], lv[2], lv[3], mix_ff[11:8], mix_ff[2:0]);
      end
   end

   assign left_mix = l_ff;
   assign right_mix = r_ff;
   assign status.div_done = dv_done;
   assign status.count_zero = (cnt_ff == 8'd0);
   assign status.master_en = en[7];
endmodule
`default_nettype wire

// File: rtl/fcsg_controller.sv
// Controller state machine: sequences divisions, tick steps and sample output.
// Depends on fcsg_pkg.
`default_nettype none
module fcsg_controller import fcsg_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire logic   req_type,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   input  wire status_type status,
   output cmd_type     cmd
);
   state_type state_ff, state_in;
   logic [3:0] sel_ff, sel_in;
   logic       acc;
   assign acc = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff; sel_in = sel_ff;
      case (state_ff)
         ST_IDLE: if (acc) begin
            if (req_type == ReqSample) state_in = ST_MIX;
            else if (status.master_en) begin state_in = ST_DIV; sel_in = DivSq1Freq; end
         end
         ST_DIV: state_in = ST_DIVWAIT;
         ST_DIVWAIT: if (status.div_done) begin
            if (sel_ff == DivRemNoi) state_in = ST_RUN;
            else begin sel_in = sel_ff + 4'd1; state_in = ST_DIV; end
         end
         ST_RUN: state_in = status.count_zero ? ST_IDLE : ST_STEP;
         ST_STEP: state_in = ST_RUN;
         ST_MIX: state_in = ST_OUT;
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = sel_ff;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      case (state_ff)
         ST_IDLE: cmd.load_count = acc;
         ST_DIV: cmd.div_start = 1'b1;
         ST_DIVWAIT: cmd.div_latch = status.div_done;
         ST_STEP: cmd.tick_step = 1'b1;
         ST_MIX: cmd.mix_go = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; sel_ff <= '0;
      end else begin
         state_ff <= state_in; sel_ff <= sel_in;
      end
   end
endmodule
`default_nettype wire
